### src/lfs_pkg.sv
// Shared types, widths and constants of the line-following steering block.
package lfs_pkg;

	// field widths
	localparam int POS_W    = 32;
	localparam int HEAD_W   = 19;
	localparam int ANGLE_W  = 19;
	localparam int TRIG_W   = 18;
	localparam int OFFSET_W = 32;
	localparam int GAIN_W   = 16;
	localparam int SPDCMD_W = 19;
	localparam int SPEED_W  = 18;
	localparam int RATE_W   = 20;
	localparam int ETA_W    = 16;
	localparam int PHI_W    = 20;
	localparam int FRAC_W   = 16;

	// configuration port
	localparam int IDX_W  = 3;
	localparam int DATA_W = 32;

	// digit-serial multiply-accumulate
	localparam int ACC_W      = 52;
	localparam int MC_W       = 33;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 5;
	localparam int COEF_W     = DIGIT_W * NUM_DIGITS;
	localparam int DCNT_W     = $clog2(NUM_DIGITS);

	// limits, Q.16
	localparam logic signed [PHI_W-1:0]    PI_Q16     = PHI_W'(205887);
	localparam logic signed [PHI_W-1:0]    TWO_PI_Q16 = PHI_W'(411775);
	localparam logic signed [ACC_W-1:0]    ETA_LIM    = ACC_W'(26214);
	localparam logic signed [ACC_W-1:0]    RATE_LIM   = ACC_W'(411566);
	localparam logic signed [SPDCMD_W-1:0] SPEED_LIM  = SPDCMD_W'(65536);

	// register reset values
	localparam logic [ANGLE_W-1:0]  RST_LINE_ANGLE    = ANGLE_W'(0);
	localparam logic [TRIG_W-1:0]   RST_LINE_COS      = TRIG_W'(65536);
	localparam logic [TRIG_W-1:0]   RST_LINE_SIN      = TRIG_W'(0);
	localparam logic [OFFSET_W-1:0] RST_LINE_OFFSET   = OFFSET_W'(0);
	localparam logic [GAIN_W-1:0]   RST_GAIN_LATERAL  = GAIN_W'(5898);
	localparam logic [GAIN_W-1:0]   RST_GAIN_HEADING  = GAIN_W'(2621);
	localparam logic [GAIN_W-1:0]   RST_GAIN_RATE     = GAIN_W'(1966);
	localparam logic [SPDCMD_W-1:0] RST_SPEED_COMMAND = SPDCMD_W'(0);

	typedef enum logic [IDX_W-1:0] {
		CFG_LINE_ANGLE    = 3'd0,
		CFG_LINE_COS      = 3'd1,
		CFG_LINE_SIN      = 3'd2,
		CFG_LINE_OFFSET   = 3'd3,
		CFG_GAIN_LATERAL  = 3'd4,
		CFG_GAIN_HEADING  = 3'd5,
		CFG_GAIN_RATE     = 3'd6,
		CFG_SPEED_COMMAND = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]  line_angle;
		logic [TRIG_W-1:0]   line_cos;
		logic [TRIG_W-1:0]   line_sin;
		logic [OFFSET_W-1:0] line_offset;
		logic [GAIN_W-1:0]   gain_lateral;
		logic [GAIN_W-1:0]   gain_heading;
		logic [GAIN_W-1:0]   gain_rate;
		logic [SPDCMD_W-1:0] speed_command;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic              preset_en;
		logic [ACC_W-1:0]  preset;
		logic [COEF_W-1:0] coef;
		logic [MC_W-1:0]   mcand;
		logic              sub;
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

endpackage

### src/lfs_pose_if.sv
// Pose request channel: robot position and heading.
interface lfs_pose_if;
	import lfs_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [HEAD_W-1:0] heading;

	modport source (output valid, output pos_x, output pos_y, output heading, input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

### src/lfs_cmd_if.sv
// Command request channel: drive speed and turn rate.
interface lfs_cmd_if;
	import lfs_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] drive_speed;
	logic signed [RATE_W-1:0]  turn_rate;

	modport source (output valid, output drive_speed, output turn_rate, input ready);
	modport sink (input valid, input drive_speed, input turn_rate, output ready);
endinterface

### src/lfs_cfg.sv
// Configuration register file of the steering block.
module lfs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [lfs_pkg::IDX_W-1:0]   wr_index,
	input  logic [lfs_pkg::DATA_W-1:0]  wr_data,
	output lfs_pkg::cfg_t               cfg
);
	import lfs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_angle    <= RST_LINE_ANGLE;
			cfg_q.line_cos      <= RST_LINE_COS;
			cfg_q.line_sin      <= RST_LINE_SIN;
			cfg_q.line_offset   <= RST_LINE_OFFSET;
			cfg_q.gain_lateral  <= RST_GAIN_LATERAL;
			cfg_q.gain_heading  <= RST_GAIN_HEADING;
			cfg_q.gain_rate     <= RST_GAIN_RATE;
			cfg_q.speed_command <= RST_SPEED_COMMAND;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_LINE_ANGLE:    cfg_q.line_angle    <= wr_data[ANGLE_W-1:0];
				CFG_LINE_COS:      cfg_q.line_cos      <= wr_data[TRIG_W-1:0];
				CFG_LINE_SIN:      cfg_q.line_sin      <= wr_data[TRIG_W-1:0];
				CFG_LINE_OFFSET:   cfg_q.line_offset   <= wr_data[OFFSET_W-1:0];
				CFG_GAIN_LATERAL:  cfg_q.gain_lateral  <= wr_data[GAIN_W-1:0];
				CFG_GAIN_HEADING:  cfg_q.gain_heading  <= wr_data[GAIN_W-1:0];
				CFG_GAIN_RATE:     cfg_q.gain_rate     <= wr_data[GAIN_W-1:0];
				CFG_SPEED_COMMAND: cfg_q.speed_command <= wr_data[SPDCMD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

### src/lfs_mac.sv
// Digit-serial multiply-accumulate unit, one 4-bit coefficient digit per cycle.
module lfs_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lfs_pkg::mac_cmd_t                  cmd,
	output lfs_pkg::mac_stat_t                 stat,
	output logic signed [lfs_pkg::ACC_W-1:0]   acc
);
	import lfs_pkg::*;

	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       mcand_q;
	logic [COEF_W-1:0]             coef_q;
	logic [DCNT_W-1:0]             cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          last;
	logic signed [DIGIT_W:0]       digit;
	logic signed [ACC_W+DIGIT_W:0] prod;
	logic signed [ACC_W-1:0]       mc_ext;

	assign last = (cnt_q == DCNT_W'(NUM_DIGITS - 1));

	// top digit carries the sign of the coefficient
	assign digit = last ? $signed({coef_q[DIGIT_W-1], coef_q[DIGIT_W-1:0]})
	                    : $signed({1'b0, coef_q[DIGIT_W-1:0]});
	assign prod   = mcand_q * digit;
	assign mc_ext = {{(ACC_W-MC_W){cmd.mcand[MC_W-1]}}, cmd.mcand};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.preset_en) begin
				acc_q <= cmd.preset;
			end
			mcand_q <= cmd.sub ? (ACC_W'(0) - mc_ext) : mc_ext;
			coef_q  <= cmd.coef;
		end else if (busy_q) begin
			// wraparound is harmless: the final sum fits the accumulator
			acc_q   <= acc_q + prod[ACC_W-1:0];
			mcand_q <= mcand_q <<< DIGIT_W;
			coef_q  <= coef_q >> DIGIT_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DCNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign acc       = acc_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("multiply started while busy");
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q && cnt_q == '0)
		else $error("multiply did not begin at first digit");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last && !cmd.start) |=> done_q && !busy_q)
		else $error("multiply did not finish after last digit");
endmodule

### src/line_following_steering.sv
// Top level of the line-following steering controller.
// A pose request is accepted only while idle, so the block takes no new pose before
// the last command is loaded; five 5-digit passes through the shared
// digit-serial multiply-accumulate unit compute each command.
// Reset: registers take their listed values, the stored turn rate clears to zero,
// no command is pending.
module line_following_steering (
	input  logic                        clk,
	input  logic                        arst_n,
	lfs_pose_if.sink                    pose,
	lfs_cmd_if.source                   cmd,
	input  logic                        wr_en,
	input  logic [lfs_pkg::IDX_W-1:0]   wr_index,
	input  logic [lfs_pkg::DATA_W-1:0]  wr_data
);
	import lfs_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_COS  = 8'b0000_0010,
		ST_SIN  = 8'b0000_0100,
		ST_ETA  = 8'b0000_1000,
		ST_LAT  = 8'b0001_0000,
		ST_HEAD = 8'b0010_0000,
		ST_RATE = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	cfg_t                      cfg;
	mac_cmd_t                  mac_cmd;
	mac_stat_t                 mac_stat;
	logic signed [ACC_W-1:0]   acc;

	state_t                    state_q;
	state_t                    state_d;
	logic signed [POS_W-1:0]   px_q;
	logic signed [PHI_W-1:0]   phi_q;
	logic signed [ETA_W-1:0]   eta_q;
	logic signed [RATE_W-1:0]  last_rate_q;
	logic                      cmd_valid_q;
	logic signed [SPEED_W-1:0] drive_q;
	logic signed [RATE_W-1:0]  turn_q;

	logic                      accept;
	logic                      out_free;
	logic                      load_out;
	logic signed [PHI_W-1:0]   phi_raw;
	logic signed [PHI_W-1:0]   phi_wrap;
	logic signed [RATE_W-1:0]  eta_sat;
	logic signed [RATE_W-1:0]  rate_sat;
	logic signed [SPDCMD_W-1:0] speed_sat;
	logic [ACC_W-1:0]          off_preset;
	logic [ACC_W-1:0]          rate_preset;

	lfs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	lfs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.stat   (mac_stat),
		.acc    (acc)
	);

	// floor to Q.16, then saturate
	function automatic logic signed [RATE_W-1:0] clamp_q16(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] lim
	);
		logic signed [ACC_W-1:0] q;
		q = a >>> FRAC_W;
		if (q > lim) begin
			return lim[RATE_W-1:0];
		end else if (q < -lim) begin
			q = -lim;
			return q[RATE_W-1:0];
		end
		return q[RATE_W-1:0];
	endfunction

	assign pose.ready = (state_q == ST_IDLE);
	assign accept     = pose.valid && pose.ready;
	assign out_free   = !cmd_valid_q || cmd.ready;
	assign load_out   = (state_q == ST_FIN) && out_free;

	// heading error, one wrap step covers every reachable difference
	assign phi_raw = PHI_W'($signed(pose.heading)) - PHI_W'($signed(cfg.line_angle));
	always_comb begin
		if (phi_raw >= PI_Q16) begin
			phi_wrap = phi_raw - TWO_PI_Q16;
		end else if (phi_raw <= -PI_Q16) begin
			phi_wrap = phi_raw + TWO_PI_Q16;
		end else begin
			phi_wrap = phi_raw;
		end
	end

	assign eta_sat  = clamp_q16(acc, ETA_LIM);
	assign rate_sat = clamp_q16(acc, RATE_LIM);

	always_comb begin
		if ($signed(cfg.speed_command) > SPEED_LIM) begin
			speed_sat = SPEED_LIM;
		end else if ($signed(cfg.speed_command) < -SPEED_LIM) begin
			speed_sat = -SPEED_LIM;
		end else begin
			speed_sat = $signed(cfg.speed_command);
		end
	end

	assign off_preset  = ACC_W'(0) - ACC_W'($signed({cfg.line_offset, FRAC_W'(0)}));
	assign rate_preset = ACC_W'($signed({last_rate_q, FRAC_W'(0)}));

	// sequencer: issue one multiply pass per product term
	always_comb begin
		state_d           = state_q;
		mac_cmd.start     = 1'b0;
		mac_cmd.preset_en = 1'b0;
		mac_cmd.preset    = rate_preset;
		mac_cmd.coef      = {{(COEF_W-GAIN_W){1'b0}}, cfg.gain_rate};
		mac_cmd.mcand     = MC_W'(last_rate_q);
		mac_cmd.sub       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				mac_cmd.preset_en = 1'b1;
				mac_cmd.preset    = off_preset;
				mac_cmd.coef      = COEF_W'($signed(cfg.line_cos));
				mac_cmd.mcand     = MC_W'(pose.pos_y);
				mac_cmd.sub       = 1'b0;
				if (accept) begin
					mac_cmd.start = 1'b1;
					state_d       = ST_COS;
				end
			end
			ST_COS: begin
				mac_cmd.coef  = COEF_W'($signed(cfg.line_sin));
				mac_cmd.mcand = MC_W'(px_q);
				if (mac_stat.done) begin
					mac_cmd.start = 1'b1;
					state_d       = ST_SIN;
				end
			end
			ST_SIN: begin
				if (mac_stat.done) begin
					state_d = ST_ETA;
				end
			end
			ST_ETA: begin
				mac_cmd.start     = 1'b1;
				mac_cmd.preset_en = 1'b1;
				mac_cmd.coef      = {{(COEF_W-GAIN_W){1'b0}}, cfg.gain_lateral};
				mac_cmd.mcand     = MC_W'(eta_q);
				state_d           = ST_LAT;
			end
			ST_LAT: begin
				mac_cmd.coef  = {{(COEF_W-GAIN_W){1'b0}}, cfg.gain_heading};
				mac_cmd.mcand = MC_W'(phi_q);
				if (mac_stat.done) begin
					mac_cmd.start = 1'b1;
					state_d       = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (mac_stat.done) begin
					mac_cmd.start = 1'b1;
					state_d       = ST_RATE;
				end
			end
			ST_RATE: begin
				if (mac_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold the sum until the output register frees up
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_valid_q <= 1'b0;
			last_rate_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				cmd_valid_q <= 1'b1;
				last_rate_q <= rate_sat;
			end else if (cmd.ready) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= pose.pos_x;
			phi_q <= phi_wrap;
		end
		if (state_q == ST_SIN && mac_stat.done) begin
			eta_q <= eta_sat[ETA_W-1:0];
		end
		if (load_out) begin
			drive_q <= speed_sat[SPEED_W-1:0];
			turn_q  <= rate_sat;
		end
	end

	assign cmd.valid       = cmd_valid_q;
	assign cmd.drive_speed = drive_q;
	assign cmd.turn_rate   = turn_q;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mac_stat.busy)
		else $error("multiplier busy while sequencer idle");
	a_accept_go: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_COS) && mac_stat.busy)
		else $error("pose request did not start the first product");
	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> cmd.valid && (state_q == ST_IDLE))
		else $error("finished command not presented");
endmodule

### tb/tb_line_following_steering.sv
// Testbench of the line-following steering block: directed and random poses checked against a predictor.
`timescale 1ns / 1ps

module tb_line_following_steering;
	import lfs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_POSES = 180;
	localparam int MAX_PRINTS = 100;

	typedef struct {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [HEAD_W-1:0] heading;
		logic                     drain_first;
	} pose_req_t;

	typedef struct {
		logic signed [SPEED_W-1:0] drive_speed;
		logic signed [RATE_W-1:0]  turn_rate;
	} cmd_exp_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [DATA_W-1:0] wr_data;

	lfs_pose_if pose_ch();
	lfs_cmd_if cmd_ch();

	line_following_steering uut (
		.clk(clk),
		.arst_n(arst_n),
		.pose(pose_ch),
		.cmd(cmd_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// predictor state
	cfg_t line_cfg;
	logic signed [RATE_W-1:0] held_rate;

	pose_req_t pose_backlog[$];
	cmd_exp_t expected_cmds[$];
	pose_req_t next_pose;
	cmd_exp_t due_cmd;
	logic pose_taken;
	int send_idle_pct;
	int stall_pct;
	int queued_cnt;
	int accepted_cnt;
	int result_cnt;
	int err_cnt;
	int cycle_cnt;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		if (err_cnt < MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic longint saturate(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	task automatic predict_steering(input pose_req_t p);
		longint cs, sn, off, eta, phi, prev, acc, rate, spd;
		cmd_exp_t e;
		cs  = longint'(signed'(line_cfg.line_cos));
		sn  = longint'(signed'(line_cfg.line_sin));
		off = longint'(signed'(line_cfg.line_offset));
		eta = (cs * longint'(p.pos_y) - sn * longint'(p.pos_x) - (off <<< FRAC_W)) >>> FRAC_W;
		eta = saturate(eta, longint'(ETA_LIM));
		phi = longint'(p.heading) - longint'(signed'(line_cfg.line_angle));
		repeat (3) begin
			if (phi <= -longint'(PI_Q16))
				phi += longint'(TWO_PI_Q16);
			else if (phi >= longint'(PI_Q16))
				phi -= longint'(TWO_PI_Q16);
		end
		prev = longint'(held_rate);
		acc = (prev <<< FRAC_W)
			- longint'(line_cfg.gain_lateral) * eta
			- longint'(line_cfg.gain_heading) * phi
			- longint'(line_cfg.gain_rate) * prev;
		rate = saturate(acc >>> FRAC_W, longint'(RATE_LIM));
		held_rate = RATE_W'(rate);
		spd = saturate(longint'(signed'(line_cfg.speed_command)), longint'(SPEED_LIM));
		e.drive_speed = SPEED_W'(spd);
		e.turn_rate = RATE_W'(rate);
		expected_cmds.push_back(e);
	endtask

	// write every register; bits above a register's width carry noise
	task automatic load_config(input cfg_t c);
		logic [DATA_W-1:0] word;
		for (int i = 0; i <= int'(CFG_SPEED_COMMAND); i++) begin
			word = $urandom;
			case (cfg_idx_t'(i))
				CFG_LINE_ANGLE:    word[ANGLE_W-1:0] = c.line_angle;
				CFG_LINE_COS:      word[TRIG_W-1:0] = c.line_cos;
				CFG_LINE_SIN:      word[TRIG_W-1:0] = c.line_sin;
				CFG_LINE_OFFSET:   word[OFFSET_W-1:0] = c.line_offset;
				CFG_GAIN_LATERAL:  word[GAIN_W-1:0] = c.gain_lateral;
				CFG_GAIN_HEADING:  word[GAIN_W-1:0] = c.gain_heading;
				CFG_GAIN_RATE:     word[GAIN_W-1:0] = c.gain_rate;
				CFG_SPEED_COMMAND: word[SPDCMD_W-1:0] = c.speed_command;
				default: ;
			endcase
			@(negedge clk);
			wr_en <= 1'b1;
			wr_index <= cfg_idx_t'(i);
			wr_data <= word;
		end
		@(negedge clk);
		wr_en <= 1'b0;
		line_cfg = c;
	endtask

	function automatic longint pick_setting(input longint lo, input longint hi,
	                                        input longint usual);
		case ($urandom_range(19))
			0, 1, 2: return lo;
			3, 4, 5: return hi;
			6, 7:    return longint'($urandom);
			default: return usual;
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		int th;
		real ang;
		th = int'($urandom_range(2 * 205887)) - 205887;
		ang = th / 65536.0;
		c.line_angle = ANGLE_W'(pick_setting(-205887, 205887, th));
		c.line_cos = TRIG_W'(pick_setting(-65536, 65536, int'(65536.0 * $cos(ang))));
		c.line_sin = TRIG_W'(pick_setting(-65536, 65536, int'(65536.0 * $sin(ang))));
		c.line_offset = OFFSET_W'(pick_setting(-64'sd2147483648, 64'sd2147483647,
			longint'($urandom_range(524288)) - 262144));
		c.gain_lateral = GAIN_W'(pick_setting(0, 65535, $urandom_range(12000)));
		c.gain_heading = GAIN_W'(pick_setting(0, 65535, $urandom_range(12000)));
		c.gain_rate = GAIN_W'(pick_setting(0, 65535, $urandom_range(12000)));
		c.speed_command = SPDCMD_W'(pick_setting(-131072, 131072,
			longint'($urandom_range(262144)) - 131072));
		return c;
	endfunction

	function automatic pose_req_t make_pose(input logic signed [POS_W-1:0] x,
	                                        input logic signed [POS_W-1:0] y,
	                                        input logic signed [HEAD_W-1:0] h);
		pose_req_t p;
		p.pos_x = x;
		p.pos_y = y;
		p.heading = h;
		p.drain_first = 1'b0;
		return p;
	endfunction

	// mostly poses close to the line, with lateral errors on both sides of the clamp limit
	function automatic pose_req_t random_pose();
		pose_req_t p;
		longint cs, sn, lat, along;
		if ($urandom_range(7) == 0) begin
			p.pos_x = $urandom;
			p.pos_y = $urandom;
		end else begin
			cs = longint'(signed'(line_cfg.line_cos));
			sn = longint'(signed'(line_cfg.line_sin));
			lat = longint'($urandom_range(78642)) - 39321
				+ longint'(signed'(line_cfg.line_offset));
			along = longint'($urandom_range(1 << 21)) - (1 << 20);
			p.pos_x = POS_W'((cs * along - sn * lat) >>> FRAC_W);
			p.pos_y = POS_W'((sn * along + cs * lat) >>> FRAC_W);
		end
		case ($urandom_range(3))
			0: p.heading = HEAD_W'($urandom);
			1: p.heading = HEAD_W'(longint'($urandom_range(411772)) - 205886);
			default: p.heading = HEAD_W'(longint'(signed'(line_cfg.line_angle))
				+ longint'($urandom_range(65536)) - 32768);
		endcase
		p.drain_first = 1'b0;
		return p;
	endfunction

	task automatic queue_pose(input pose_req_t p);
		longint phi;
		phi = longint'(p.heading) - longint'(signed'(line_cfg.line_angle));
		// the wrap has no fixed point with phi exactly on the pi boundary; step off it
		if (phi == longint'(PI_Q16) || phi == longint'(PI_Q16) + 1)
			p.heading -= 4;
		else if (phi == -longint'(PI_Q16) || phi == -longint'(PI_Q16) - 1)
			p.heading += 4;
		pose_backlog.push_back(p);
		queued_cnt++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pose_backlog.size() != 0 || accepted_cnt != queued_cnt
			|| expected_cmds.size() != 0);
	endtask

	// pose driver and result ready, both on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			pose_ch.valid <= 1'b0;
		end else if (!pose_ch.valid || pose_taken) begin
			if (pose_backlog.size() != 0
				&& !(pose_backlog[0].drain_first && expected_cmds.size() != 0)
				&& $urandom_range(99) >= send_idle_pct) begin
				next_pose = pose_backlog.pop_front();
				pose_ch.valid <= 1'b1;
				pose_ch.pos_x <= next_pose.pos_x;
				pose_ch.pos_y <= next_pose.pos_y;
				pose_ch.heading <= next_pose.heading;
			end else begin
				pose_ch.valid <= 1'b0;
			end
		end
		cmd_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// monitor: predict on accepted poses, check accepted commands
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_line_following_steering: errors");
			$finish;
		end else begin
			pose_taken <= arst_n && pose_ch.valid && pose_ch.ready;
			if (arst_n && pose_ch.valid && pose_ch.ready) begin
				predict_steering(make_pose(pose_ch.pos_x, pose_ch.pos_y, pose_ch.heading));
				accepted_cnt++;
			end
			if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
				if (expected_cmds.size() == 0) begin
					flag_error($sformatf("command with none due: speed %0d rate %0d",
						cmd_ch.drive_speed, cmd_ch.turn_rate));
				end else begin
					due_cmd = expected_cmds.pop_front();
					if (cmd_ch.drive_speed !== due_cmd.drive_speed)
						flag_error($sformatf("command %0d drive_speed %0d, expected %0d",
							result_cnt, cmd_ch.drive_speed, due_cmd.drive_speed));
					if (cmd_ch.turn_rate !== due_cmd.turn_rate)
						flag_error($sformatf("command %0d turn_rate %0d, expected %0d",
							result_cnt, cmd_ch.turn_rate, due_cmd.turn_rate));
				end
				result_cnt++;
			end
		end
	end

	initial begin : stimulus
		cfg_t c;
		pose_req_t p;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_LINE_ANGLE;
		wr_data = '0;
		pose_ch.valid = 1'b0;
		pose_ch.pos_x = '0;
		pose_ch.pos_y = '0;
		pose_ch.heading = '0;
		cmd_ch.ready = 1'b0;
		pose_taken = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		queued_cnt = 0;
		accepted_cnt = 0;
		result_cnt = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		held_rate = '0;
		line_cfg.line_angle = RST_LINE_ANGLE;
		line_cfg.line_cos = RST_LINE_COS;
		line_cfg.line_sin = RST_LINE_SIN;
		line_cfg.line_offset = RST_LINE_OFFSET;
		line_cfg.gain_lateral = RST_GAIN_LATERAL;
		line_cfg.gain_heading = RST_GAIN_HEADING;
		line_cfg.gain_rate = RST_GAIN_RATE;
		line_cfg.speed_command = RST_SPEED_COMMAND;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: lateral clamp edges, position and heading extremes
		queue_pose(make_pose(0, 0, 0));
		queue_pose(make_pose(0, 32'h7fffffff, 0));
		queue_pose(make_pose(0, 32'h80000000, 0));
		queue_pose(make_pose(0, 26214, 0));
		queue_pose(make_pose(0, 26215, 205886));
		queue_pose(make_pose(0, -1, -205886));
		queue_pose(make_pose(32'h7fffffff, -26215, 262143));
		queue_pose(make_pose(32'h80000000, 12345, -262144));
		queue_pose(make_pose(-1, -1, -1));
		queue_pose(make_pose(32'h55555555, 32'haaaaaaaa, 19'h2aaaa));
		wait_drained();

		// full gains, no damping: drive the turn rate into both limits
		c.line_angle = '0;
		c.line_cos = '0;
		c.line_sin = TRIG_W'(-65536);
		c.line_offset = '0;
		c.gain_lateral = 16'hffff;
		c.gain_heading = 16'hffff;
		c.gain_rate = '0;
		c.speed_command = SPDCMD_W'(131072);
		load_config(c);
		@(posedge clk);
		repeat (3) queue_pose(make_pose(0, 0, 205886));
		repeat (3) queue_pose(make_pose(0, 0, -205886));
		queue_pose(make_pose(32'h7fffffff, 0, 0));
		queue_pose(make_pose(32'h80000000, 0, 0));
		queue_pose(make_pose(100, 0, -262144));
		queue_pose(make_pose(-26214, 0, 262143));
		wait_drained();

		// opposite extremes: only the damping term acts
		c.line_angle = ANGLE_W'(205887);
		c.line_cos = TRIG_W'(-65536);
		c.line_sin = TRIG_W'(65536);
		c.line_offset = 32'h80000000;
		c.gain_lateral = '0;
		c.gain_heading = '0;
		c.gain_rate = 16'hffff;
		c.speed_command = SPDCMD_W'(-131072);
		load_config(c);
		@(posedge clk);
		queue_pose(make_pose(1, 2, 5));
		queue_pose(make_pose(-3, 7, -5));
		queue_pose(make_pose(0, 0, 100000));
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 50; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 50; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			load_config(random_config());
			@(posedge clk);
			for (int n = 0; n < PHASE_POSES; n++) begin
				p = random_pose();
				// hold this request until the pipeline has emptied
				p.drain_first = (n == PHASE_POSES / 3);
				queue_pose(p);
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_cnt == 0)
			$display("tb_line_following_steering: clean");
		else
			$display("tb_line_following_steering: errors");
		$finish;
	end

endmodule
